>>> hdl/fpa_pkg.sv
// Shared types, operation codes and constants for the Q24.8 fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

	localparam int FRAC_BITS = 8;
	localparam int WORD_BITS = 32;
	localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int Q_DEPTH   = 4;
	localparam int Q_PTR_W   = $clog2(Q_DEPTH);

	localparam logic [WORD_BITS-1:0] W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic [WORD_BITS-1:0] W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_FROM_INT = 4'd14,
		OP_TO_INT   = 4'd15
	} op_t;

	// Work class decided by the front end
	typedef enum logic [1:0] {
		K_SIMPLE = 2'd0,
		K_MUL    = 2'd1,
		K_DIV    = 2'd2
	} kind_t;

	// Classified word held in the queue
	typedef struct packed {
		kind_t                kind;
		logic                 neg;
		logic [WORD_BITS-1:0] mag_a;
		logic [WORD_BITS-1:0] mag_b;
		logic [WORD_BITS-1:0] res;
		logic                 cmp;
		logic                 dbz;
		logic                 ovf;
	} item_t;

	// One stage of the execution pipeline
	typedef struct packed {
		logic [PROD_BITS-1:0] acc;
		logic [WORD_BITS-1:0] rem;
		logic [WORD_BITS-1:0] dsr;
		kind_t                kind;
		logic                 neg;
		logic                 cmp;
		logic                 dbz;
		logic                 ovf;
	} stage_t;

endpackage
`default_nettype wire

>>> hdl/fpa_front.sv
// Front end: decodes the action and finishes every operation except multiply and divide by a nonzero divisor.
`timescale 1ns / 1ps
`default_nettype none
module fpa_front (
	input  wire logic [3:0]                   action,
	input  wire logic [fpa_pkg::WORD_BITS-1:0] operand_a,
	input  wire logic [fpa_pkg::WORD_BITS-1:0] operand_b,
	output fpa_pkg::item_t                     item
);

	localparam int W = fpa_pkg::WORD_BITS;
	localparam int F = fpa_pkg::FRAC_BITS;

	fpa_pkg::op_t op;
	logic         sub;
	logic [W-1:0] rhs;
	logic [W:0]   sum;
	logic         add_ovf;
	logic [W-1:0] add_res;
	logic         lt, gt, eq;
	logic         fi_ok;
	logic [W-1:0] fi_res;

	assign op = fpa_pkg::op_t'(action);

	// Shared saturating adder for add, sub, inc and dec
	assign sub = (op == fpa_pkg::OP_SUB) || (op == fpa_pkg::OP_DEC);
	assign rhs = ((op == fpa_pkg::OP_INC) || (op == fpa_pkg::OP_DEC)) ?
		W'(1) : operand_b;
	assign sum = sub ? ({operand_a[W-1], operand_a} - {rhs[W-1], rhs}) :
		({operand_a[W-1], operand_a} + {rhs[W-1], rhs});
	assign add_ovf = sum[W] != sum[W-1];
	assign add_res = add_ovf ? (operand_a[W-1] ? fpa_pkg::W_MIN : fpa_pkg::W_MAX) : sum[W-1:0];

	// Signed relations
	assign lt = $signed(operand_a) < $signed(operand_b);
	assign gt = $signed(operand_b) < $signed(operand_a);
	assign eq = operand_a == operand_b;

	// Integer to fixed fits when the top bits are pure sign
	assign fi_ok  = (&operand_a[W-1:W-1-F]) || ~(|operand_a[W-1:W-1-F]);
	assign fi_res = fi_ok ? {operand_a[W-1-F:0], {F{1'b0}}} :
		(operand_a[W-1] ? fpa_pkg::W_MIN : fpa_pkg::W_MAX);

	// Classify and fill the queue word
	always_comb begin
		item.kind  = fpa_pkg::K_SIMPLE;
		item.neg   = operand_a[W-1] ^ operand_b[W-1];
		item.mag_a = operand_a[W-1] ? (~operand_a + W'(1)) : operand_a;
		item.mag_b = operand_b[W-1] ? (~operand_b + W'(1)) : operand_b;
		item.res   = '0;
		item.cmp   = 1'b0;
		item.dbz   = 1'b0;
		item.ovf   = 1'b0;
		unique case (op)
			fpa_pkg::OP_ADD, fpa_pkg::OP_SUB,
			fpa_pkg::OP_INC, fpa_pkg::OP_DEC: begin
				item.res = add_res;
				item.ovf = add_ovf;
			end
			fpa_pkg::OP_MUL: item.kind = fpa_pkg::K_MUL;
			fpa_pkg::OP_DIV: begin
				if (operand_b == '0) begin
					item.dbz = 1'b1;
				end else begin
					item.kind = fpa_pkg::K_DIV;
				end
			end
			fpa_pkg::OP_GT: item.cmp = gt;
			fpa_pkg::OP_LT: item.cmp = lt;
			fpa_pkg::OP_GE: item.cmp = ~lt;
			fpa_pkg::OP_LE: item.cmp = ~gt;
			fpa_pkg::OP_EQ: item.cmp = eq;
			fpa_pkg::OP_NE: item.cmp = ~eq;
			fpa_pkg::OP_MIN: item.res = lt ? operand_a : operand_b;
			fpa_pkg::OP_MAX: item.res = gt ? operand_a : operand_b;
			fpa_pkg::OP_FROM_INT: begin
				item.res = fi_res;
				item.ovf = ~fi_ok;
			end
			fpa_pkg::OP_TO_INT: item.res = W'($signed(operand_a) >>> F);
			default: item.res = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> hdl/fpa_queue.sv
// Short queue of classified words between front end and execution pipeline.
`timescale 1ns / 1ps
`default_nettype none
module fpa_queue (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire fpa_pkg::item_t push_data,
	input  wire logic  pop_en,
	output logic       pop_valid,
	output fpa_pkg::item_t pop_data
);

	localparam int D  = fpa_pkg::Q_DEPTH;
	localparam int PW = fpa_pkg::Q_PTR_W;

	fpa_pkg::item_t mem_q [D];
	logic [PW-1:0]  wr_q, rd_q;
	logic [PW:0]    cnt_q;
	logic           push, pop;

	assign push_ready = cnt_q != (PW+1)'(D);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_en && pop_valid;
	assign pop_data   = mem_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(D-1)) ? '0 : wr_q + PW'(1);
			if (pop) rd_q <= (rd_q == PW'(D-1)) ? '0 : rd_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= (PW+1)'(D))
		else $error("queue fill count past depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !pop)
		else $error("pop from empty queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + (PW+1)'(1)))
		else $error("queue count missed a push");

endmodule
`default_nettype wire

>>> hdl/fpa_back.sv
// Execution pipeline: multiplier, bit-per-stage divider, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none
module fpa_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pop_valid,
	input  wire fpa_pkg::item_t                pop_data,
	output logic                               pop_en,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [fpa_pkg::WORD_BITS-1:0]      result_value,
	output logic                               compare_true,
	output logic                               divide_by_zero,
	output logic                               overflow
);

	localparam int W  = fpa_pkg::WORD_BITS;
	localparam int F  = fpa_pkg::FRAC_BITS;
	localparam int QB = fpa_pkg::QUO_BITS;
	localparam int PB = fpa_pkg::PROD_BITS;
	localparam int NS = QB;

	fpa_pkg::stage_t stg_q [NS+1];
	logic            vld_q [NS+1];
	logic            adv;

	// Whole pipeline moves unless the output word is stuck
	assign adv    = !out_valid || out_ready;
	assign pop_en = adv;

	// Entry stage: multiply, load the dividend or pass the simple result
	always_ff @(posedge clk) begin
		if (adv) begin
			stg_q[0].kind <= pop_data.kind;
			stg_q[0].neg  <= pop_data.neg;
			stg_q[0].cmp  <= pop_data.cmp;
			stg_q[0].dbz  <= pop_data.dbz;
			stg_q[0].ovf  <= pop_data.ovf;
			stg_q[0].rem  <= '0;
			stg_q[0].dsr  <= pop_data.mag_b;
			unique case (pop_data.kind)
				fpa_pkg::K_MUL: stg_q[0].acc <= pop_data.mag_a * pop_data.mag_b;
				fpa_pkg::K_DIV: stg_q[0].acc <= PB'({pop_data.mag_a, {F{1'b0}}});
				default:        stg_q[0].acc <= PB'(pop_data.res);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= pop_valid;
		end
	end

	// Divider: one quotient bit per stage, dividend shifts out as quotient shifts in
	for (genvar i = 1; i <= NS; i++) begin : g_div
		logic [W:0]      trial;
		logic [W:0]      diff;
		logic            ge;
		fpa_pkg::stage_t nxt;

		assign trial = {stg_q[i-1].rem, stg_q[i-1].acc[QB-1]};
		assign diff  = trial - {1'b0, stg_q[i-1].dsr};
		assign ge    = trial >= {1'b0, stg_q[i-1].dsr};

		// Next stage word: divides take one quotient step, others pass through
		always_comb begin
			nxt = stg_q[i-1];
			if (stg_q[i-1].kind == fpa_pkg::K_DIV) begin
				nxt.rem = ge ? diff[W-1:0] : trial[W-1:0];
				nxt.acc = {stg_q[i-1].acc[PB-1:QB], stg_q[i-1].acc[QB-2:0], ge};
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				stg_q[i] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (adv) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// Rounding and saturation of the last stage
	fpa_pkg::stage_t fin;
	logic [QB:0]     div_rnd;
	logic [PB:0]     mul_sum;
	logic [PB-1:0]   mag;
	logic [PB-1:0]   limit;
	logic            sat;
	logic [W-1:0]    val;

	assign fin     = stg_q[NS];
	assign div_rnd = {1'b0, fin.acc[QB-1:0]} +
		(QB+1)'({fin.rem, 1'b0} >= {1'b0, fin.dsr});
	assign mul_sum = {1'b0, fin.acc} + (PB+1)'(1 << (F-1));
	assign mag     = (fin.kind == fpa_pkg::K_MUL) ? PB'(mul_sum >> F) : PB'(div_rnd);
	assign limit   = fin.neg ? PB'(fpa_pkg::W_MIN) : PB'(fpa_pkg::W_MAX);
	assign sat     = mag > limit;

	always_comb begin
		if (fin.kind == fpa_pkg::K_SIMPLE) begin
			val = fin.acc[W-1:0];
		end else if (sat) begin
			val = fin.neg ? fpa_pkg::W_MIN : fpa_pkg::W_MAX;
		end else begin
			val = fin.neg ? (~mag[W-1:0] + W'(1)) : mag[W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv) begin
			result_value   <= val;
			compare_true   <= fin.cmp;
			divide_by_zero <= fin.dbz;
			overflow       <= (fin.kind == fpa_pkg::K_SIMPLE) ? fin.ovf : sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= vld_q[NS];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(compare_true && overflow))
		else $error("compare and overflow both set");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && divide_by_zero) |-> (result_value == '0 && !overflow))
		else $error("divide by zero word carries a value");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && compare_true) |-> (result_value == '0))
		else $error("comparison word carries a value");

endmodule
`default_nettype wire

>>> hdl/fixed_point_alu_q24_8_top.sv
// Every operation takes the same path from input accept to output word:
// queue, entry stage, 40 divider stages and output register.
// Throughput: one word per cycle while the output is not stalled; the 40-stage bit-per-stage divider sets depth.
// A 4-word queue lets the input keep accepting while the output is stalled, until the queue is full.
// Reset (arst_n, async, active low) clears queue pointers and all valid bits.
`timescale 1ns / 1ps
`default_nettype none
module fixed_point_alu_q24_8_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  action,
	input  wire logic [31:0] operand_a,
	input  wire logic [31:0] operand_b,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      result_value,
	output logic             compare_true,
	output logic             divide_by_zero,
	output logic             overflow
);

	fpa_pkg::item_t item, pop_data;
	logic           pop_en, pop_valid;

	fpa_front u_front (
		.action    (action),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.item      (item)
	);

	fpa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_ready (in_ready),
		.push_data  (item),
		.pop_en     (pop_en),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data)
	);

	fpa_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_data       (pop_data),
		.pop_en         (pop_en),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_value   (result_value),
		.compare_true   (compare_true),
		.divide_by_zero (divide_by_zero),
		.overflow       (overflow)
	);

endmodule
`default_nettype wire
